// ----- src/periodic_task_scheduler_assert.svh -----
// assertion macros for the periodic task scheduler
`ifndef PERIODIC_TASK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/psched_pkg.sv -----
// types, constants and helper functions for the periodic task scheduler
`timescale 1ns / 1ps

package psched_pkg;

    // task table geometry
    localparam int TASKS       = 4;
    localparam int PERIOD_BITS = 16;
    localparam int TASK_W      = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int FIELD_W     = 16;
    localparam int FIELD_SHIFT = $clog2(FIELD_W);
    localparam int CYCLE_W     = 22;
    localparam int BUDGET_W    = 16;
    localparam int MASK_W      = 4;
    localparam int SEL_W       = 2;
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // slack divides reported cycles by 40: a shift by 3, then times 1/5
    localparam int SLACK_DIVISOR   = 40;
    localparam int SLACK_PRE_SHIFT = $clog2(8);
    localparam int PRE_W           = CYCLE_W - SLACK_PRE_SHIFT;
    localparam int RECIP_W         = 19;
    localparam int RECIP_SHIFT     = 21;
    // ceil(2^21 / 5), exact for every value below 2^19
    localparam logic [RECIP_W-1:0] SLACK_RECIP = RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5);
    localparam int PROD_W          = PRE_W + RECIP_W;
    localparam int QUOT_W          = PROD_W - RECIP_SHIFT;

    // signed metric: wide enough for a full period and for negative slack
    localparam int METRIC_W = 18;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_DONE   = 2'd1,
        REQ_CYCLES = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        POL_PERIOD   = 2'd0,
        POL_DEADLINE = 2'd1,
        POL_SLACK    = 2'd2
    } t_policy;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY  = 2'd0,
        CFG_PERIODS = 2'd1,
        CFG_BUDGETS = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EVAL,
        ST_DONE
    } t_state;

    // a zero period stands for the full counter range
    function automatic logic [PERIOD_BITS:0] eff_period(input logic [PERIOD_BITS-1:0] p);
        logic [PERIOD_BITS:0] full;
        full = {1'b1, {PERIOD_BITS{1'b0}}};
        return (p == '0) ? full : {1'b0, p};
    endfunction

endpackage

// ----- src/periodic_task_scheduler.sv -----
// periodic task scheduler top level: task table, sequencer and result register
// input stalls until the item is through: per task, two passes of the shared metric unit
//   (multiply, then metric and compare), then the result load and the return to idle
// reset: synchronous, active low; all tasks pending, counters and cycles zero,
//   policy least slack, periods and budgets zero; no clearing pass
`timescale 1ns / 1ps

`include "periodic_task_scheduler_assert.svh"

module periodic_task_scheduler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [psched_pkg::REQ_W-1:0]          i_req_type,
    input  logic [1:0]                            i_task_index,
    input  logic [psched_pkg::CYCLE_W-1:0]        i_cycles_run,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [psched_pkg::SEL_W-1:0]          o_selected_task,
    output logic                                  o_idle,
    output logic [psched_pkg::MASK_W-1:0]         o_missed_mask,
    output logic [psched_pkg::MASK_W-1:0]         o_released_mask,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [psched_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psched_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    psched_pkg::t_state r_state, n_state;

    // configuration
    logic [1:0]                           r_policy;
    logic [psched_pkg::CFG_DATA_W-1:0]    r_periods;
    logic [psched_pkg::CFG_DATA_W-1:0]    r_budgets;

    // task table
    logic [psched_pkg::PERIOD_BITS-1:0]   r_phase   [psched_pkg::TASKS];
    logic [psched_pkg::CYCLE_W-1:0]       r_cycles  [psched_pkg::TASKS];
    logic [psched_pkg::TASKS-1:0]         r_pending;

    // per-item work registers
    logic [psched_pkg::REQ_W-1:0]         r_req;
    logic [psched_pkg::TASK_W-1:0]        r_task;
    logic [psched_pkg::TASKS-1:0]         r_missed;
    logic [psched_pkg::TASKS-1:0]         r_released;
    logic                                 r_found;
    logic [psched_pkg::TASK_W-1:0]        r_sel;
    logic signed [psched_pkg::METRIC_W-1:0] r_best;

    // result register
    logic                                 r_out_valid;
    logic [psched_pkg::SEL_W-1:0]         r_out_sel;
    logic                                 r_out_idle;
    logic [psched_pkg::MASK_W-1:0]        r_out_missed;
    logic [psched_pkg::MASK_W-1:0]        r_out_released;

    logic                                 w_accept;
    logic                                 w_idx_ok;
    logic [psched_pkg::TASK_W-1:0]        w_idx;
    logic                                 w_upd;
    logic                                 w_eval;
    logic                                 w_load_out;
    logic                                 w_last;
    logic [psched_pkg::PERIOD_BITS-1:0]   w_period;
    logic [psched_pkg::BUDGET_W-1:0]      w_budget;
    logic [psched_pkg::PERIOD_BITS:0]     w_eff;
    logic [psched_pkg::PERIOD_BITS:0]     w_next;
    logic                                 w_wrap;
    logic                                 w_better;
    logic signed [psched_pkg::METRIC_W-1:0] w_metric;

    // handshake
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = i_rst_n;
    assign w_idx       = i_task_index[psched_pkg::TASK_W-1:0];
    assign w_idx_ok    = ({1'b0, i_task_index} < 3'(psched_pkg::TASKS));
    assign w_last      = (r_task == psched_pkg::TASK_W'(psched_pkg::TASKS - 1));

    // fields of the task under work
    assign w_period = r_periods[{r_task, psched_pkg::FIELD_SHIFT'(0)} +: psched_pkg::PERIOD_BITS];
    assign w_budget = r_budgets[{r_task, psched_pkg::FIELD_SHIFT'(0)} +: psched_pkg::BUDGET_W];

    // tick step for the task under work
    assign w_eff  = psched_pkg::eff_period(w_period);
    assign w_next = {1'b0, r_phase[r_task]} + (psched_pkg::PERIOD_BITS + 1)'(1);
    assign w_wrap = (w_next >= w_eff);

    // shared metric unit
    psched_eval u_eval (
        .i_clk    (i_clk),
        .i_load   (w_upd),
        .i_cycles (r_cycles[r_task]),
        .i_period (w_period),
        .i_phase  (r_phase[r_task]),
        .i_budget (w_budget),
        .i_policy (r_policy),
        .o_metric (w_metric)
    );

    assign w_better = r_pending[r_task] && (!r_found || (w_metric < r_best));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psched_pkg::ST_IDLE:   if (w_accept) n_state = psched_pkg::ST_UPDATE;
            psched_pkg::ST_UPDATE: n_state = psched_pkg::ST_EVAL;
            psched_pkg::ST_EVAL:   n_state = w_last ? psched_pkg::ST_DONE : psched_pkg::ST_UPDATE;
            psched_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = psched_pkg::ST_IDLE;
            end
            default:               n_state = psched_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_upd      = 1'b0;
        w_eval     = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            psched_pkg::ST_IDLE:   o_in_stall = !i_rst_n;
            psched_pkg::ST_UPDATE: w_upd = 1'b1;
            psched_pkg::ST_EVAL:   w_eval = 1'b1;
            psched_pkg::ST_DONE:   w_load_out = !r_out_valid || !i_out_stall;
            default:               o_in_stall = 1'b1;
        endcase
    end

    // control state, configuration and task table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psched_pkg::ST_IDLE;
            r_task      <= '0;
            r_out_valid <= 1'b0;
            r_policy    <= psched_pkg::POL_SLACK;
            r_periods   <= '0;
            r_budgets   <= '0;
            r_pending   <= '1;
            for (int t = 0; t < psched_pkg::TASKS; t++) begin
                r_phase[t]  <= '0;
                r_cycles[t] <= '0;
            end
        end else begin
            r_state <= n_state;

            // configuration write transfer
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (psched_pkg::t_cfg_idx'(i_cfg_index))
                    psched_pkg::CFG_POLICY:  r_policy  <= i_cfg_data[1:0];
                    psched_pkg::CFG_PERIODS: r_periods <= i_cfg_data;
                    psched_pkg::CFG_BUDGETS: r_budgets <= i_cfg_data;
                    default: ;
                endcase
            end

            // finish and cycle reports take effect on the input transfer
            if (w_accept) begin
                r_task <= '0;
                if (w_idx_ok) begin
                    case (psched_pkg::t_req'(i_req_type))
                        psched_pkg::REQ_DONE:   r_pending[w_idx] <= 1'b0;
                        psched_pkg::REQ_CYCLES: r_cycles[w_idx]  <= i_cycles_run;
                        default: ;
                    endcase
                end
            end

            // tick: advance the phase, release or keep pending at the boundary
            if (w_upd && (r_req == psched_pkg::REQ_TICK)) begin
                if (w_wrap) begin
                    r_phase[r_task]   <= '0;
                    r_pending[r_task] <= 1'b1;
                end else begin
                    r_phase[r_task] <= w_next[psched_pkg::PERIOD_BITS-1:0];
                end
            end

            if (w_eval && !w_last) begin
                r_task <= r_task + psched_pkg::TASK_W'(1);
            end

            // result register
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item payload: request, masks and running best
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req      <= i_req_type;
            r_missed   <= '0;
            r_released <= '0;
            r_found    <= 1'b0;
        end
        if (w_upd && (r_req == psched_pkg::REQ_TICK) && w_wrap) begin
            if (r_pending[r_task]) begin
                r_missed[r_task] <= 1'b1;
            end else begin
                r_released[r_task] <= 1'b1;
            end
        end
        // strict compare keeps the lower index on a tie
        if (w_eval && w_better) begin
            r_found <= 1'b1;
            r_best  <= w_metric;
            r_sel   <= r_task;
        end
        if (w_load_out) begin
            r_out_sel      <= r_found ? psched_pkg::SEL_W'(r_sel) : '0;
            r_out_idle     <= !r_found;
            r_out_missed   <= psched_pkg::MASK_W'(r_missed);
            r_out_released <= psched_pkg::MASK_W'(r_released);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_selected_task = r_out_sel;
    assign o_idle          = r_out_idle;
    assign o_missed_mask   = r_out_missed;
    assign o_released_mask = r_out_released;

    // assertions
    `PTS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid && (r_state == psched_pkg::ST_IDLE), "reset did not clear sequencer or result")
    `PTS_ASSERT(a_accept_starts, i_clk, i_rst_n, w_accept |=> (r_state == psched_pkg::ST_UPDATE) && (r_task == '0), "input transfer did not start the task walk at task zero")
    `PTS_ASSERT(a_walk_steps, i_clk, i_rst_n, (r_state == psched_pkg::ST_EVAL) && !w_last |=> (r_state == psched_pkg::ST_UPDATE) && (r_task == psched_pkg::TASK_W'($past(r_task) + 1'b1)), "task walk skipped or repeated a task")
    `PTS_ASSERT(a_masks_disjoint, i_clk, i_rst_n, o_out_valid |-> ((o_missed_mask & o_released_mask) == '0), "a task is both missed and released")
    `PTS_ASSERT(a_idle_zero_sel, i_clk, i_rst_n, o_out_valid && o_idle |-> (o_selected_task == '0), "idle result carries a nonzero task")

endmodule

// ----- src/psched_eval.sv -----
// shared metric unit: reciprocal multiply for slack and the policy metric
`timescale 1ns / 1ps

module psched_eval (
    input  logic                                     i_clk,
    input  logic                                     i_load,
    input  logic [psched_pkg::CYCLE_W-1:0]           i_cycles,
    input  logic [psched_pkg::PERIOD_BITS-1:0]       i_period,
    input  logic [psched_pkg::PERIOD_BITS-1:0]       i_phase,
    input  logic [psched_pkg::BUDGET_W-1:0]          i_budget,
    input  logic [1:0]                               i_policy,
    output logic signed [psched_pkg::METRIC_W-1:0]   o_metric
);

    logic [psched_pkg::PRE_W-1:0]         w_pre;
    logic [psched_pkg::PROD_W-1:0]        r_prod;
    logic [psched_pkg::QUOT_W-1:0]        w_quot;
    logic [psched_pkg::PERIOD_BITS:0]     w_eff;
    logic [psched_pkg::PERIOD_BITS:0]     w_phase_ext;
    logic [psched_pkg::PERIOD_BITS:0]     w_dist;
    logic signed [psched_pkg::METRIC_W-1:0] w_slack;

    // divide by 8 first, then multiply by the reciprocal of 5
    assign w_pre = i_cycles[psched_pkg::CYCLE_W-1:psched_pkg::SLACK_PRE_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= psched_pkg::PROD_W'(w_pre) * psched_pkg::PROD_W'(psched_pkg::SLACK_RECIP);
        end
    end

    assign w_quot = r_prod[psched_pkg::RECIP_SHIFT +: psched_pkg::QUOT_W];

    // slack is budget minus cycles / 40
    assign w_slack = $signed(psched_pkg::METRIC_W'(i_budget))
                   - $signed(psched_pkg::METRIC_W'(w_quot));

    // ticks to next boundary, one tick when the phase is already at or past it
    assign w_eff       = psched_pkg::eff_period(i_period);
    assign w_phase_ext = {1'b0, i_phase};
    assign w_dist      = (w_phase_ext < w_eff) ? (w_eff - w_phase_ext)
                                               : (psched_pkg::PERIOD_BITS + 1)'(1);

    // policy select, code three behaves as least slack
    always_comb begin
        unique case (i_policy)
            psched_pkg::POL_PERIOD:   o_metric = $signed(psched_pkg::METRIC_W'(w_eff));
            psched_pkg::POL_DEADLINE: o_metric = $signed(psched_pkg::METRIC_W'(w_dist));
            default:                  o_metric = w_slack;
        endcase
    end

endmodule

// ----- test/psched_tb_pkg.sv -----
// scoreboard class that predicts and checks the task picks of the periodic task scheduler
`timescale 1ns / 1ps

package psched_tb_pkg;

    import psched_pkg::*;

    // one result transfer
    typedef struct packed {
        logic [SEL_W-1:0]  sel;
        logic              idle;
        logic [MASK_W-1:0] missed;
        logic [MASK_W-1:0] released;
    } t_sched_pick;

    class sched_scoreboard;

        // shadow configuration
        logic [1:0]            policy;
        logic [CFG_DATA_W-1:0] periods;
        logic [CFG_DATA_W-1:0] budgets;

        // shadow task table
        logic [PERIOD_BITS-1:0] phase [TASKS];
        bit                     pending [TASKS];
        logic [CYCLE_W-1:0]     cycles_seen [TASKS];

        t_sched_pick expected_picks [$];
        logic [SEL_W-1:0] last_pick;
        int mismatches;

        function new();
            policy = POL_SLACK;
            periods = '0;
            budgets = '0;
            for (int t = 0; t < TASKS; t++) begin
                phase[t] = '0;
                pending[t] = 1'b1;
                cycles_seen[t] = '0;
            end
            last_pick = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_POLICY:  policy = data[1:0];
                CFG_PERIODS: periods = data;
                CFG_BUDGETS: budgets = data;
                default: ;
            endcase
        endfunction

        // period in ticks, a zero field meaning the full counter range
        function logic [PERIOD_BITS:0] period_of(int t);
            logic [PERIOD_BITS-1:0] p;
            logic [PERIOD_BITS:0]   span;
            p = periods[t*FIELD_W +: PERIOD_BITS];
            span = {1'b0, p};
            if (p == 0) span[PERIOD_BITS] = 1'b1;
            return span;
        endfunction

        // ordering key of one task under the current policy, lowest wins
        function longint rank_of(int t);
            logic [PERIOD_BITS:0] span;
            span = period_of(t);
            case (policy)
                POL_PERIOD:   return longint'(span);
                POL_DEADLINE: return ({1'b0, phase[t]} < span) ?
                                     longint'(span - phase[t]) : 64'sd1;
                default:      return longint'(budgets[t*FIELD_W +: BUDGET_W]) -
                                     longint'(cycles_seen[t] / SLACK_DIVISOR);
            endcase
        endfunction

        // update the table for one accepted request and queue the pick it causes
        function void note_request(logic [REQ_W-1:0] req, logic [1:0] idx,
                                   logic [CYCLE_W-1:0] cyc);
            t_sched_pick          r;
            logic [PERIOD_BITS:0] span;
            logic [PERIOD_BITS:0] step;
            longint               best;
            longint               rank;
            bit                   found;
            r = '0;
            found = 1'b0;
            best = 0;
            case (t_req'(req))
                REQ_TICK: begin
                    for (int t = 0; t < TASKS; t++) begin
                        span = period_of(t);
                        step = {1'b0, phase[t]} + 1'b1;
                        if (step >= span) begin
                            phase[t] = '0;
                            if (pending[t]) begin
                                r.missed[t] = 1'b1;
                            end else begin
                                pending[t] = 1'b1;
                                r.released[t] = 1'b1;
                            end
                        end else begin
                            phase[t] = step[PERIOD_BITS-1:0];
                        end
                    end
                end
                REQ_DONE:   pending[idx] = 1'b0;
                REQ_CYCLES: cycles_seen[idx] = cyc;
                default: ;
            endcase
            for (int t = 0; t < TASKS; t++) begin
                if (pending[t]) begin
                    rank = rank_of(t);
                    if (!found || rank < best) begin
                        found = 1'b1;
                        best = rank;
                        r.sel = SEL_W'(t);
                    end
                end
            end
            r.idle = !found;
            last_pick = r.sel;
            expected_picks.push_back(r);
        endfunction

        task log_mismatch(string what, logic [7:0] got, logic [7:0] want);
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_pick(t_sched_pick got);
            t_sched_pick want;
            if (expected_picks.size() == 0) begin
                log_mismatch("unexpected result transfer", 8'(got), 8'h0);
            end else begin
                want = expected_picks.pop_front();
                if (got.sel !== want.sel)
                    log_mismatch("selected_task", 8'(got.sel), 8'(want.sel));
                if (got.idle !== want.idle)
                    log_mismatch("idle", 8'(got.idle), 8'(want.idle));
                if (got.missed !== want.missed)
                    log_mismatch("missed_mask", 8'(got.missed), 8'(want.missed));
                if (got.released !== want.released)
                    log_mismatch("released_mask", 8'(got.released), 8'(want.released));
            end
        endtask

        // anything still queued at the end never came out
        task flush_expected();
            t_sched_pick want;
            while (expected_picks.size() != 0) begin
                want = expected_picks.pop_front();
                log_mismatch("missing result transfer", 8'h0, 8'(want));
            end
        endtask

        function int outstanding();
            return expected_picks.size();
        endfunction

    endclass

endpackage

// ----- test/tb_periodic_task_scheduler.sv -----
// testbench top for the periodic task scheduler: stimulus, handshakes and scoreboard hookup
`timescale 1ns / 1ps

module tb_periodic_task_scheduler;

    import psched_pkg::*;
    import psched_tb_pkg::*;

    // codes the package does not name
    localparam logic [1:0]           POL_SLACK_ALIAS = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;

    localparam int SETTLE_CYCLES   = 2*TASKS + 6;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 135;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [REQ_W-1:0]      i_req_type;
    logic [1:0]            i_task_index;
    logic [CYCLE_W-1:0]    i_cycles_run;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [SEL_W-1:0]      o_selected_task;
    logic                  o_idle;
    logic [MASK_W-1:0]     o_missed_mask;
    logic [MASK_W-1:0]     o_released_mask;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sched_scoreboard sb = new();
    bit steady = 1'b0;
    int unsigned cycle_count = 0;

    periodic_task_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_task_index    (i_task_index),
        .i_cycles_run    (i_cycles_run),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_selected_task (o_selected_task),
        .o_idle          (o_idle),
        .o_missed_mask   (o_missed_mask),
        .o_released_mask (o_released_mask),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result transfers go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_pick('{sel: o_selected_task, idle: o_idle,
                            missed: o_missed_mask, released: o_released_mask});
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!steady) begin
                n = pick_gap();
                if (n != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // one input transfer; valid drops at the falling edge after the transfer
    task automatic send_item(t_req req, logic [1:0] idx, logic [CYCLE_W-1:0] cyc);
        int gap;
        gap = steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_task_index <= idx;
        i_cycles_run <= cyc;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req, idx, cyc);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // stop sending and wait until every expected pick has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_config(logic [1:0] pol, logic [CFG_DATA_W-1:0] per,
                               logic [CFG_DATA_W-1:0] bud);
        write_cfg(CFG_POLICY, CFG_DATA_W'(pol));
        write_cfg(CFG_PERIODS, per);
        write_cfg(CFG_BUDGETS, bud);
    endtask

    function automatic logic [FIELD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return FIELD_W'($urandom_range(1, 6));
        if (r < 65) return '0;
        if (r < 75) return '1;
        if (r < 85) return FIELD_W'($urandom_range(7, 40));
        return FIELD_W'($urandom);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_budget();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return FIELD_W'($urandom);
        if (r < 50) return '0;
        if (r < 70) return '1;
        return FIELD_W'($urandom_range(0, 60));
    endfunction

    // cycle counts near the divide-by-40 steps and at both ends of the range
    function automatic logic [CYCLE_W-1:0] pick_cycles();
        case ($urandom_range(0, 4))
            0:       return CYCLE_W'($urandom);
            1:       return {CYCLE_W{1'b1}} - CYCLE_W'($urandom_range(0, 100));
            2:       return CYCLE_W'($urandom_range(0, 2000));
            3:       return CYCLE_W'(40 * $urandom_range(0, 3000) +
                                     ($urandom_range(0, 1) ? 39 : 0));
            default: return CYCLE_W'($urandom_range(0, 200000));
        endcase
    endfunction

    // mostly runs the task that was just picked, with reports for it
    task automatic random_item();
        int r;
        t_req req;
        logic [1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 40)      req = REQ_TICK;
        else if (r < 65) req = REQ_DONE;
        else if (r < 95) req = REQ_CYCLES;
        else             req = REQ_NONE;
        idx = ($urandom_range(0, 1) != 0) ? sb.last_pick : 2'($urandom_range(0, 3));
        send_item(req, idx, pick_cycles());
    endtask

    // settings of one random phase, the extremes first
    task automatic configure_phase(int ph);
        logic [1:0]            pol;
        logic [CFG_DATA_W-1:0] per;
        logic [CFG_DATA_W-1:0] bud;
        case (ph % 4)
            0:       pol = POL_PERIOD;
            1:       pol = POL_DEADLINE;
            2:       pol = POL_SLACK;
            default: pol = POL_SLACK_ALIAS;
        endcase
        for (int t = 0; t < TASKS; t++) begin
            per[t*FIELD_W +: FIELD_W] = pick_period();
            bud[t*FIELD_W +: FIELD_W] = pick_budget();
        end
        case (ph)
            0: begin
                per = {TASKS{16'h0001}};
                bud = '1;
            end
            1: begin
                per = '0;
                bud = '0;
            end
            2: per = '1;
            3: begin
                per = {$urandom, $urandom};
                bud = {$urandom, $urandom};
            end
            default: ;
        endcase
        load_config(pol, per, bud);
        if (ph % 5 == 4) write_cfg(CFG_SPARE, {$urandom, $urandom});
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_TICK;
        i_task_index = '0;
        i_cycles_run = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_POLICY;
        i_cfg_data   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: least slack, zero periods and budgets
        send_item(REQ_NONE, 2'd3, '1);
        send_item(REQ_CYCLES, 2'd0, '1);
        send_item(REQ_CYCLES, 2'd3, CYCLE_W'(40));
        send_item(REQ_CYCLES, 2'd2, CYCLE_W'(39));
        send_item(REQ_DONE, 2'd0, '0);
        send_item(REQ_TICK, 2'd0, '0);

        // shortest period, periods 1 / full range / 2 / max, spare index ignored
        wait_drained();
        load_config(POL_PERIOD, 64'hFFFF_0002_0000_0001, 64'hFFFF_8000_0000_0001);
        write_cfg(CFG_SPARE, '1);
        send_item(REQ_TICK, 2'd1, '1);
        send_item(REQ_DONE, 2'd0, '0);
        send_item(REQ_DONE, 2'd2, '0);
        send_item(REQ_TICK, 2'd0, '0);
        send_item(REQ_TICK, 2'd0, '0);
        send_item(REQ_DONE, 2'd1, '0);
        send_item(REQ_DONE, 2'd3, '0);
        send_item(REQ_DONE, 2'd0, '0);
        send_item(REQ_DONE, 2'd2, '0);
        send_item(REQ_TICK, 2'd0, '0);

        // earliest deadline with task 3's period cut below its phase
        wait_drained();
        load_config(POL_DEADLINE, 64'h0002_0002_0000_0001, 64'hFFFF_8000_0000_0001);
        send_item(REQ_NONE, 2'd0, '0);
        send_item(REQ_TICK, 2'd0, '0);

        // unused policy code behaves as least slack; cycles survive a release
        wait_drained();
        write_cfg(CFG_POLICY, CFG_DATA_W'(POL_SLACK_ALIAS));
        send_item(REQ_CYCLES, 2'd1, '0);
        send_item(REQ_CYCLES, 2'd2, 22'h155555);
        send_item(REQ_TICK, 2'd0, '0);

        // random phases; each drain holds the sender until all picks are out
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            steady = (ph % 3 == 1);
            configure_phase(ph);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) random_item();
        end

        wait_drained();
        sb.flush_expected();
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
